// ----- rtl/core/tbf_pkg.sv -----
// Shared types and constants of the tensor block footprint unit.
`default_nettype none
package tbf_pkg;
  localparam int TENSOR_SLOTS = 4096;
  localparam int BLOCK_SLOTS = 4096;
  localparam int TID_W = $clog2(TENSOR_SLOTS);
  localparam int BID_W = $clog2(BLOCK_SLOTS);
  localparam int BS_W = 41;
  localparam int OFF_W = 49;
  localparam int QDEPTH = 2;
  localparam logic [BS_W-1:0] BS_RESET = BS_W'(33554432);
  localparam logic [59:0] SUM_MAX = {60{1'b1}};
  localparam logic [52:0] P_MAX = {53{1'b1}};
  localparam logic [12:0] COUNT_MAX = 13'd8191;

  typedef struct packed {
    logic [11:0] tensor_key;
    logic [47:0] useful_bytes_in;
    logic [47:0] entry_offset;
    logic [47:0] entry_span;
    logic last;
  } in_item_t;

  typedef struct packed {
    logic [12:0] block_count;
    logic [52:0] proj_bytes;
    logic [59:0] useful_total;
    logic [52:0] excess_bytes;
    logic capacity_overflow;
  } out_item_t;

  typedef struct packed {
    logic mark;
    logic last;
    logic [47:0] offset;
    logic [47:0] span;
    logic [BS_W-1:0] bsize;
  } job_t;

  typedef enum logic [3:0] {
    B_IDLE, B_DIV1, B_DIV2, B_CHECK, B_RD, B_WAIT, B_WR,
    B_MUL, B_OUT, B_CLR
  } back_state_t;
endpackage
`default_nettype wire

// ----- rtl/core/tensor_block_footprint.sv -----
// Top level of the tensor block footprint unit.
// Channel   Handshake           Payload
// item      start / busy        in_data (in_item_t)
// config    cfg_valid/cfg_ready cfg_data (block size)
// result    done strobe         out_data (out_item_t)
// A marked item runs two 49-step divisions, then reads and marks each block of its range.
// A final item adds a clearing sweep over all 4096 entries of both bitmaps; the same sweep follows reset.
// After a final item, busy stays high until that sweep has ended.
// Reset is synchronous and active high; results cannot be stalled.
`default_nettype none
module tensor_block_footprint import tbf_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire in_item_t        in_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [BS_W-1:0] cfg_data,
  output logic                 done,
  output out_item_t            out_data
);
  logic [BS_W-1:0] block_size;
  logic job_pop, job_valid, clr_we;
  logic [TID_W-1:0] clr_addr;
  job_t job;
  logic [59:0] useful_sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) block_size <= BS_RESET;
    else if (cfg_valid) block_size <= cfg_data;
  end

  tbf_front u_front (
    .clk(clk), .rst(rst), .start(start), .item(in_data), .bsize(block_size),
    .busy(busy), .clr_we(clr_we), .clr_addr(clr_addr), .job_pop(job_pop),
    .job_valid(job_valid), .job(job), .useful_sum(useful_sum)
  );

  tbf_back u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job(job),
    .useful_sum(useful_sum), .job_pop(job_pop), .clr_we(clr_we),
    .clr_addr(clr_addr), .done(done), .result(out_data)
  );

  a_ovf_ok: assert property (@(posedge clk) disable iff (rst)
    done |-> out_data.excess_bytes <= out_data.proj_bytes)
    else $error("overfetch exceeds projected bytes");
  a_zero_blk: assert property (@(posedge clk) disable iff (rst)
    done && out_data.block_count == 13'd0 |-> out_data.proj_bytes == '0)
    else $error("projection without blocks");
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    clr_we |-> busy)
    else $error("item taken during sweep");
endmodule
`default_nettype wire

// ----- rtl/core/tbf_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module tbf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/tbf_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module tbf_div import tbf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             go,
  input  wire logic [OFF_W-1:0] dividend,
  input  wire logic [BS_W-1:0]  divisor,
  output logic                  done,
  output logic [OFF_W-1:0]      quotient
);
  logic [BS_W:0] rem;
  logic [OFF_W-1:0] q;
  logic [BS_W-1:0] dv;
  logic [5:0] cnt;
  logic running;
  logic [BS_W+1:0] trial;
  logic [BS_W:0] shifted;

  assign shifted = {rem[BS_W-1:0], q[OFF_W-1]};
  assign trial = {1'b0, shifted} - {2'b0, dv};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt <= 6'(OFF_W);
        rem <= '0;
        q <= dividend;
        dv <= (divisor == '0) ? BS_W'(1) : divisor;
      end else if (running) begin
        if (trial[BS_W+1]) begin
          rem <= shifted;
          q <= {q[OFF_W-2:0], 1'b0};
        end else begin
          rem <= trial[BS_W:0];
          q <= {q[OFF_W-2:0], 1'b1};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/tbf_front.sv -----
// Front end: duplicate filter, useful-byte sum and job queue.
`default_nettype none
module tbf_front import tbf_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire in_item_t        item,
  input  wire logic [BS_W-1:0] bsize,
  output logic                 busy,
  input  wire logic            clr_we,
  input  wire logic [TID_W-1:0] clr_addr,
  input  wire logic            job_pop,
  output logic                 job_valid,
  output job_t                 job,
  output logic [59:0]          useful_sum
);
  logic pend;
  logic closed;
  in_item_t held;
  logic [BS_W-1:0] held_bs;
  logic seen_rd;
  logic [TID_W-1:0] addr;
  logic we;
  logic wdata;
  job_t q [QDEPTH];
  logic [$clog2(QDEPTH):0] cnt;
  logic rp, wp;
  logic push;
  logic [60:0] sum_add;

  assign we = clr_we | (pend && cnt != 2'(QDEPTH));
  assign addr = clr_we ? clr_addr : (pend ? held.tensor_key : item.tensor_key);
  assign wdata = !clr_we;
  assign push = pend && !clr_we && cnt != 2'(QDEPTH);
  assign busy = pend || clr_we || closed;
  assign job_valid = cnt != '0;
  assign job = q[rp];
  assign sum_add = {1'b0, useful_sum} + 61'(held.useful_bytes_in);

  tbf_ram #(.WIDTH(1), .DEPTH(TENSOR_SLOTS)) u_seen (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(seen_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      closed <= 1'b0;
      cnt <= '0;
      rp <= 1'b0;
      wp <= 1'b0;
      useful_sum <= '0;
    end else begin
      if (start && !busy) begin
        pend <= 1'b1;
        held <= item;
        held_bs <= bsize;
      end
      if (push) begin
        pend <= 1'b0;
        q[wp].mark <= !seen_rd && held.entry_span != '0;
        q[wp].last <= held.last;
        q[wp].offset <= held.entry_offset;
        q[wp].span <= held.entry_span;
        q[wp].bsize <= held_bs;
        wp <= !wp;
        if (!seen_rd && held.entry_span != '0) begin
          useful_sum <= sum_add[60] ? SUM_MAX : sum_add[59:0];
        end
        if (held.last) begin
          closed <= 1'b1;
        end
      end
      if (clr_we && clr_addr == '0) begin
        useful_sum <= '0;
      end
      if (clr_we && clr_addr == '1) begin
        closed <= 1'b0;
      end
      if (job_pop) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(push) - 2'(job_pop);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/tbf_back.sv -----
// Back end: block range division, bitmap marking, result and clearing sweep.
`default_nettype none
module tbf_back import tbf_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            job_valid,
  input  wire job_t            job,
  input  wire logic [59:0]     useful_sum,
  output logic                 job_pop,
  output logic                 clr_we,
  output logic [TID_W-1:0]     clr_addr,
  output logic                 done,
  output out_item_t            result
);
  back_state_t state, state_next;
  job_t cur;
  logic [OFF_W-1:0] first_q, last_q;
  logic [BID_W:0] b, top;
  logic [BID_W-1:0] sweep;
  logic [12:0] count;
  logic ovf;
  logic div_go, div_done;
  logic [OFF_W-1:0] dividend, quot;
  logic mark_rd, mark_we, mark_wd;
  logic [BID_W-1:0] mark_addr;
  logic [53:0] prod;
  logic [52:0] proj;

  assign dividend = (state == B_IDLE) ? OFF_W'(job.offset)
                  : OFF_W'(cur.offset) + OFF_W'(cur.span) - OFF_W'(1);

  tbf_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(dividend),
    .divisor(state == B_IDLE ? job.bsize : cur.bsize),
    .done(div_done), .quotient(quot)
  );

  tbf_ram #(.WIDTH(1), .DEPTH(BLOCK_SLOTS)) u_marks (
    .clk(clk), .we(mark_we), .addr(mark_addr), .wdata(mark_wd), .rdata(mark_rd)
  );

  assign mark_addr = (state == B_CLR) ? sweep : b[BID_W-1:0];
  assign mark_we = (state == B_CLR) || (state == B_WR && !mark_rd);
  assign mark_wd = (state != B_CLR);
  assign clr_we = (state == B_CLR);
  assign clr_addr = TID_W'(sweep);

  always_comb begin
    state_next = state;
    job_pop = 1'b0;
    div_go = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          if (job.mark) begin
            div_go = 1'b1;
            state_next = B_DIV1;
          end else if (job.last) begin
            state_next = B_MUL;
          end
        end
      end
      B_DIV1: begin
        if (div_done) begin
          div_go = 1'b1;
          state_next = B_DIV2;
        end
      end
      B_DIV2: if (div_done) state_next = B_CHECK;
      B_CHECK: begin
        if (first_q >= OFF_W'(BLOCK_SLOTS)) begin
          state_next = cur.last ? B_MUL : B_IDLE;
        end else begin
          state_next = B_RD;
        end
      end
      B_RD: state_next = B_WAIT;
      B_WAIT: state_next = B_WR;
      B_WR: begin
        if (b == top) state_next = cur.last ? B_MUL : B_IDLE;
        else state_next = B_RD;
      end
      B_MUL: state_next = B_OUT;
      B_OUT: state_next = B_CLR;
      B_CLR: if (sweep == '1) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  assign proj = prod[53] ? P_MAX : prod[52:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLR;
      sweep <= '0;
      count <= '0;
      ovf <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (state == B_IDLE && job_valid) cur <= job;
      if (state == B_DIV1 && div_done) first_q <= quot;
      if (state == B_DIV2 && div_done) last_q <= quot;
      if (state == B_CHECK) begin
        if (last_q >= OFF_W'(BLOCK_SLOTS)) ovf <= 1'b1;
        b <= first_q[BID_W:0];
        top <= (last_q >= OFF_W'(BLOCK_SLOTS)) ? (BID_W+1)'(BLOCK_SLOTS - 1)
                                               : last_q[BID_W:0];
      end
      if (state == B_WR) begin
        if (!mark_rd && count != COUNT_MAX) count <= count + 13'd1;
        b <= b + (BID_W+1)'(1);
      end
      if (state == B_MUL) begin
        prod <= 54'(count) * 54'((cur.bsize == '0) ? BS_W'(1) : cur.bsize);
      end
      if (state == B_OUT) begin
        done <= 1'b1;
        result.block_count <= count;
        result.proj_bytes <= proj;
        result.useful_total <= useful_sum;
        result.excess_bytes <= (60'(proj) > useful_sum)
                               ? 53'(60'(proj) - useful_sum) : '0;
        result.capacity_overflow <= ovf;
        count <= '0;
        ovf <= 1'b0;
      end
      if (state == B_CLR) sweep <= sweep + BID_W'(1);
    end
  end
endmodule
`default_nettype wire
